/* rtl/lru_stack_distance_miss_counter_assert.svh */
// Assertion macros used by the block's top-level RTL.
`ifndef LRU_STACK_DISTANCE_MISS_COUNTER_ASSERT_SVH
`define LRU_STACK_DISTANCE_MISS_COUNTER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define LSDMC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define LSDMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lsdmc_pkg.sv */
package lsdmc_pkg;

    localparam int ADDR_BITS_DEF = 12;
    localparam int TIME_BITS_DEF = 16;
    localparam int LEVELS_DEF    = 4;

    localparam int SIZE_REGS   = 4;
    localparam int ACT_W       = 3;
    localparam int SIZE_W      = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int COUNT_W     = 32;
    localparam int LEVEL_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LEVELS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_ZERO     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_ONE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_TWO      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_THREE    = 3'd4;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_RESET [SIZE_REGS] = '{13'd64, 13'd256, 13'd1024, 13'd4096};

    localparam logic MODE_REPORT = 1'b1;

    typedef struct packed {
        logic               clr_step;
        logic               cap_in;
        logic               ovf_set;
        logic               cold_upd;
        logic               walk_start;
        logic               walk_rd;
        logic               walk_wr;
        logic               dist_calc;
        logic               lvl_upd;
        logic               emit_load;
        logic               emit_last;
        logic               emit_clear;
        logic [LEVEL_W-1:0] emit_idx;
    } t_cmd;

    typedef struct packed {
        logic             clr_done;
        logic             mode;
        logic             time_full;
        logic             prev_zero;
        logic             out_free;
        logic             ovf;
        logic [ACT_W-1:0] lvl_count;
    } t_stat;

endpackage

/* rtl/lsdmc_dpath.sv */
module lsdmc_dpath #(
    parameter int ADDR_BITS = lsdmc_pkg::ADDR_BITS_DEF,
    parameter int TIME_BITS = lsdmc_pkg::TIME_BITS_DEF,
    parameter int LEVELS    = lsdmc_pkg::LEVELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsdmc_pkg::t_cmd                     i_cmd,
    output lsdmc_pkg::t_stat                    o_stat,
    input  logic                                i_mode,
    input  logic [ADDR_BITS-1:0]                i_block_address,
    input  logic                                i_cfg_we,
    input  logic [lsdmc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lsdmc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [lsdmc_pkg::LEVEL_W-1:0]       o_level,
    output logic [lsdmc_pkg::COUNT_W-1:0]       o_miss_count,
    output logic                                o_overflow,
    output logic                                o_last
);

    localparam int SIZE_REGS = lsdmc_pkg::SIZE_REGS;
    localparam int ACT_W     = lsdmc_pkg::ACT_W;
    localparam int SIZE_W    = lsdmc_pkg::SIZE_W;
    localparam int COUNT_W   = lsdmc_pkg::COUNT_W;
    localparam int LEVEL_W   = lsdmc_pkg::LEVEL_W;
    localparam int NLVL      = (LEVELS < SIZE_REGS) ? LEVELS : SIZE_REGS;
    localparam int SWEEP_W   = (ADDR_BITS > TIME_BITS) ? ADDR_BITS : TIME_BITS;
    localparam int DIST_W    = SWEEP_W + 1;
    localparam int CMP_W     = (DIST_W > SIZE_W) ? DIST_W : SIZE_W;
    localparam int NODE_W    = TIME_BITS + 1;

    logic [ACT_W-1:0]     r_active;
    logic [SIZE_W-1:0]    r_size [SIZE_REGS];
    logic [TIME_BITS-1:0] r_time;
    logic [ADDR_BITS:0]   r_distinct;
    logic [COUNT_W-1:0]   r_cold;
    logic [COUNT_W-1:0]   r_lm [SIZE_REGS];
    logic                 r_ovf;
    logic [SWEEP_W-1:0]   r_sweep;

    logic [TIME_BITS-1:0] r_lat_mem [2**ADDR_BITS];
    logic [TIME_BITS-1:0] r_lat_q;
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_mode;

    logic [NODE_W-1:0]    r_tree_mem [2**TIME_BITS];
    logic [NODE_W-1:0]    r_tree_q;

    logic [TIME_BITS-1:0] r_tsh;
    logic [TIME_BITS-1:0] r_node;
    logic [TIME_BITS-1:0] r_p_node;
    logic                 r_p_bit;
    logic [NODE_W-1:0]    r_older;
    logic [DIST_W-1:0]    r_dist;

    logic                 r_out_valid;
    logic [LEVEL_W-1:0]   r_out_level;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_ovf;
    logic                 r_out_last;

    logic [ACT_W-1:0]     lvl_count;
    logic [SIZE_REGS-1:0] miss;
    logic [DIST_W-1:0]    diff;
    logic [COUNT_W:0]     sum;
    logic [COUNT_W-1:0]   sum_sat;

    logic                 lat_we;
    logic [ADDR_BITS-1:0] lat_wa;
    logic [TIME_BITS-1:0] lat_wd;
    logic                 tree_we;
    logic [TIME_BITS-1:0] tree_wa;
    logic [NODE_W-1:0]    tree_wd;

    always_comb begin
        if (r_active == '0) begin
            lvl_count = ACT_W'(1);
        end else if (r_active > ACT_W'(NLVL)) begin
            lvl_count = ACT_W'(NLVL);
        end else begin
            lvl_count = r_active;
        end
    end

    // A level misses while every size up to and including it fits within the distance.
    always_comb begin
        logic run;
        run = 1'b1;
        for (int i = 0; i < SIZE_REGS; i++) begin
            run     = run & (CMP_W'(r_size[i]) <= CMP_W'(r_dist));
            miss[i] = run & (ACT_W'(i) < lvl_count);
        end
    end

    assign diff    = DIST_W'(r_lat_q) - DIST_W'(r_older);
    assign sum     = {1'b0, r_lm[i_cmd.emit_idx]} + {1'b0, r_cold};
    assign sum_sat = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];

    assign lat_we  = i_cmd.clr_step | i_cmd.cold_upd | i_cmd.lvl_upd;
    assign lat_wa  = i_cmd.clr_step ? r_sweep[ADDR_BITS-1:0] : r_addr;
    assign lat_wd  = i_cmd.clr_step ? '0 : r_time + TIME_BITS'(1);

    assign tree_we = i_cmd.clr_step | (i_cmd.walk_wr & ~r_p_bit);
    assign tree_wa = i_cmd.clr_step ? r_sweep[TIME_BITS-1:0] : r_p_node;
    assign tree_wd = i_cmd.clr_step ? '0 : r_tree_q + NODE_W'(1);

    always_ff @(posedge i_clk) begin
        if (lat_we) begin
            r_lat_mem[lat_wa] <= lat_wd;
        end
        if (i_cmd.cap_in) begin
            r_lat_q <= r_lat_mem[i_block_address];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tree_we) begin
            r_tree_mem[tree_wa] <= tree_wd;
        end
        if (i_cmd.walk_rd) begin
            r_tree_q <= r_tree_mem[r_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_addr <= i_block_address;
            r_mode <= i_mode;
        end
        if (i_cmd.walk_start) begin
            r_tsh   <= r_lat_q;
            r_node  <= TIME_BITS'(1);
            r_older <= '0;
        end
        if (i_cmd.walk_rd) begin
            r_p_node <= r_node;
            r_p_bit  <= r_tsh[TIME_BITS-1];
            r_node   <= {r_node[TIME_BITS-2:0], r_tsh[TIME_BITS-1]};
            r_tsh    <= {r_tsh[TIME_BITS-2:0], 1'b0};
        end
        if (i_cmd.walk_wr && r_p_bit) begin
            r_older <= r_older + r_tree_q;
        end
        if (i_cmd.dist_calc) begin
            r_dist <= DIST_W'(r_distinct) - diff;
        end
        if (i_cmd.emit_load) begin
            r_out_level <= i_cmd.emit_idx;
            r_out_count <= sum_sat;
            r_out_ovf   <= r_ovf;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= lsdmc_pkg::ACTIVE_RESET;
            for (int i = 0; i < SIZE_REGS; i++) begin
                r_size[i] <= lsdmc_pkg::SIZE_RESET[i];
                r_lm[i]   <= '0;
            end
            r_time      <= '0;
            r_distinct  <= '0;
            r_cold      <= '0;
            r_ovf       <= 1'b0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lsdmc_pkg::CFG_ACTIVE_LEVELS: r_active  <= i_cfg_data[ACT_W-1:0];
                    lsdmc_pkg::CFG_SIZE_ZERO:     r_size[0] <= i_cfg_data[SIZE_W-1:0];
                    lsdmc_pkg::CFG_SIZE_ONE:      r_size[1] <= i_cfg_data[SIZE_W-1:0];
                    lsdmc_pkg::CFG_SIZE_TWO:      r_size[2] <= i_cfg_data[SIZE_W-1:0];
                    lsdmc_pkg::CFG_SIZE_THREE:    r_size[3] <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_step) begin
                r_sweep <= r_sweep + SWEEP_W'(1);
            end
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.cold_upd) begin
                if (r_cold != '1) begin
                    r_cold <= r_cold + COUNT_W'(1);
                end
                r_distinct <= r_distinct + (ADDR_BITS+1)'(1);
                r_time     <= r_time + TIME_BITS'(1);
            end
            if (i_cmd.lvl_upd) begin
                for (int i = 0; i < SIZE_REGS; i++) begin
                    if (miss[i] && r_lm[i] != '1) begin
                        r_lm[i] <= r_lm[i] + COUNT_W'(1);
                    end
                end
                r_time <= r_time + TIME_BITS'(1);
            end
            if (i_cmd.emit_clear) begin
                r_cold <= '0;
                for (int i = 0; i < SIZE_REGS; i++) begin
                    r_lm[i] <= '0;
                end
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clr_done  = &r_sweep;
    assign o_stat.mode      = r_mode;
    assign o_stat.time_full = &r_time;
    assign o_stat.prev_zero = (r_lat_q == '0);
    assign o_stat.out_free  = ~r_out_valid | ~i_out_stall;
    assign o_stat.ovf       = r_ovf;
    assign o_stat.lvl_count = lvl_count;

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_out_level;
    assign o_miss_count = r_out_count;
    assign o_overflow   = r_out_ovf;
    assign o_last       = r_out_last;

endmodule

/* rtl/lsdmc_ctrl.sv */
module lsdmc_ctrl #(
    parameter int TIME_BITS = lsdmc_pkg::TIME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lsdmc_pkg::t_stat i_stat,
    output lsdmc_pkg::t_cmd  o_cmd
);

    localparam int ACT_W   = lsdmc_pkg::ACT_W;
    localparam int LEVEL_W = lsdmc_pkg::LEVEL_W;
    localparam int STEP_W  = $clog2(TIME_BITS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DIST  = 3'd4;
    localparam logic [2:0] S_LEVEL = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [LEVEL_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.emit_idx  = r_idx;
        o_cmd.emit_last = ((ACT_W'(r_idx) + ACT_W'(1)) == i_stat.lvl_count);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.mode == lsdmc_pkg::MODE_REPORT) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else if (i_stat.time_full) begin
                    o_cmd.ovf_set = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_stat.prev_zero) begin
                    o_cmd.cold_upd = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_step           = '0;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                // read one tree level per cycle, update the level read the cycle before
                o_cmd.walk_rd = (r_step != STEP_W'(TIME_BITS));
                o_cmd.walk_wr = (r_step != '0);
                if (r_step == STEP_W'(TIME_BITS)) begin
                    n_state = S_DIST;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DIST: begin
                o_cmd.dist_calc = 1'b1;
                n_state         = S_LEVEL;
            end
            S_LEVEL: begin
                o_cmd.lvl_upd = 1'b1;
                n_state       = S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (o_cmd.emit_last) begin
                        o_cmd.emit_clear = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_idx = r_idx + LEVEL_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/lru_stack_distance_miss_counter.sv */
// LRU stack-distance miss counter. Each access beat (mode 0) looks up the block's last
// timestamp and, on a re-access, walks a counting tree over retired timestamps to find how
// many distinct blocks were touched since, then counts a miss for every configured cache size
// that does not exceed that distance; a first-time access counts as a cold miss for all sizes.
// A report beat (mode 1) returns one result per active size (miss count including cold misses,
// saturating at 32 bits, plus the sticky timestamp overflow flag) and clears the counts.
// A re-access is paced by the tree walk, which reads one tree level per cycle from the
// single-read-port tree memory; no new beat is taken until the current one is done, and a
// report also waits while the output is stalled. After reset, a clearing pass over all
// 2**max(ADDR_BITS, TIME_BITS) sweep addresses zeroes both memories; input is stalled
// until it ends, while configuration writes are taken. Write configuration only while the
// block is idle.
module lru_stack_distance_miss_counter #(
    parameter int ADDR_BITS = lsdmc_pkg::ADDR_BITS_DEF,
    parameter int TIME_BITS = lsdmc_pkg::TIME_BITS_DEF,
    parameter int LEVELS    = lsdmc_pkg::LEVELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [ADDR_BITS-1:0]              i_block_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lsdmc_pkg::LEVEL_W-1:0]     o_level,
    output logic [lsdmc_pkg::COUNT_W-1:0]     o_miss_count,
    output logic                              o_overflow,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [lsdmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsdmc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    `include "lru_stack_distance_miss_counter_assert.svh"

    localparam int ACT_W = lsdmc_pkg::ACT_W;

    lsdmc_pkg::t_cmd  w_cmd;
    lsdmc_pkg::t_stat w_stat;

    lsdmc_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lsdmc_dpath #(
        .ADDR_BITS (ADDR_BITS),
        .TIME_BITS (TIME_BITS),
        .LEVELS    (LEVELS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (i_mode),
        .i_block_address (i_block_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_level         (o_level),
        .o_miss_count    (o_miss_count),
        .o_overflow      (o_overflow),
        .o_last          (o_last)
    );

    `LSDMC_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while previous beat still in work")
    `LSDMC_ASSERT_NEXT(a_overflow_sticky, i_clk, i_rst_n, w_stat.ovf, w_stat.ovf, "overflow flag dropped")
    `LSDMC_ASSERT_SAME(a_level_in_range, i_clk, i_rst_n, o_out_valid, ACT_W'(o_level) < w_stat.lvl_count, "result level beyond active sizes")

endmodule

/* tb/lru_stack_distance_miss_counter_test.sv */
module lru_stack_distance_miss_counter_test;

    localparam int AW = lsdmc_pkg::ADDR_BITS_DEF;
    localparam int TIME_W = lsdmc_pkg::TIME_BITS_DEF;
    localparam int LEVEL_W = lsdmc_pkg::LEVEL_W;
    localparam int COUNT_W = lsdmc_pkg::COUNT_W;
    localparam int CFG_INDEX_W = lsdmc_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W = lsdmc_pkg::CFG_DATA_W;
    localparam int SIZE_REGS = lsdmc_pkg::SIZE_REGS;
    localparam int ACT_W = lsdmc_pkg::ACT_W;
    localparam int SIZE_W = lsdmc_pkg::SIZE_W;
    localparam int PHASES = 7;
    localparam int DIRECTED_ROWS = 14;
    localparam int RANDOM_PER_PHASE = 18;
    localparam int SETTLE_CYCLES = 50;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam logic MODE_ACCESS = ~lsdmc_pkg::MODE_REPORT;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] miss_count;
        logic               overflow;
        logic               last;
    } t_miss_report;

    typedef struct packed {
        logic               mode;
        logic [AW-1:0]      addr;
        logic               typed;
        logic [COUNT_W-1:0] misses;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_mode;
    logic [AW-1:0]          i_block_address;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [LEVEL_W-1:0]     o_level;
    logic [COUNT_W-1:0]     o_miss_count;
    logic                   o_overflow;
    logic                   o_last;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    logic                   has_typed_count;
    logic [COUNT_W-1:0]     typed_count;
    logic                   steady = 1'b0;

    // LRU stack of block addresses, most recent first
    logic [AW-1:0]          recency [$];
    logic [TIME_W-1:0]      stamp_count;
    logic [COUNT_W-1:0]     cold_total;
    logic [COUNT_W-1:0]     size_misses [SIZE_REGS];
    logic                   overflow_seen;
    logic [ACT_W-1:0]       cfg_levels;
    logic [SIZE_W-1:0]      cfg_size [SIZE_REGS];

    t_miss_report           pending_counts [$];
    int                     faults = 0;
    int                     counts_seen = 0;
    int                     accesses_sent = 0;
    int                     reports_sent = 0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{lsdmc_pkg::MODE_REPORT, 12'hFFF, 1'b1, 32'd0},
        '{MODE_ACCESS, 12'h000, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'hFFF, 1'b0, 32'd0},
        '{lsdmc_pkg::MODE_REPORT, 12'h000, 1'b1, 32'd2},
        '{MODE_ACCESS, 12'h000, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'h000, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'hAAA, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'h555, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'h0F0, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'hFFF, 1'b0, 32'd0},
        '{lsdmc_pkg::MODE_REPORT, 12'hAAA, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'h555, 1'b0, 32'd0},
        '{MODE_ACCESS, 12'h0F0, 1'b0, 32'd0},
        '{lsdmc_pkg::MODE_REPORT, 12'h555, 1'b0, 32'd0}
    };

    // active levels, then sizes zero to three
    logic [CFG_DATA_W-1:0] setting_table [PHASES][SIZE_REGS+1] = '{
        '{13'd7, 13'd0,    13'd2,    13'd1,    13'd8191},
        '{13'd0, 13'd3,    13'd5,    13'd9,    13'd12},
        '{13'd4, 13'd1,    13'd2,    13'd4,    13'd8},
        '{13'd2, 13'd2,    13'd6,    13'd6,    13'd4096},
        '{13'd6, 13'd0,    13'd4,    13'd3,    13'd5},
        '{13'd5, 13'd4096, 13'd4096, 13'd4096, 13'd4096},
        '{13'd1, 13'd8191, 13'd0,    13'd0,    13'd0}
    };

    lru_stack_distance_miss_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_block_address (i_block_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_level         (o_level),
        .o_miss_count    (o_miss_count),
        .o_overflow      (o_overflow),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * 4);
        $display("timeout with %0d count beats outstanding", pending_counts.size());
        $display("status: fail");
        $finish;
    end

    function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic int levels_in_use();
        int n;
        n = cfg_levels;
        if (n < 1) n = 1;
        if (n > lsdmc_pkg::LEVELS_DEF) n = lsdmc_pkg::LEVELS_DEF;
        if (n > SIZE_REGS) n = SIZE_REGS;
        return n;
    endfunction

    function automatic void apply_access(input logic [AW-1:0] addr);
        int pos;
        int k;
        int n;
        if (stamp_count == '1) begin
            overflow_seen = 1'b1;
            return;
        end
        pos = -1;
        for (k = 0; k < recency.size(); k++) begin
            if (recency[k] == addr) begin
                pos = k;
                break;
            end
        end
        if (pos < 0) begin
            cold_total = sat_bump(cold_total);
        end else begin
            recency.delete(pos);
            n = levels_in_use();
            for (k = 0; k < n; k++) begin
                if (cfg_size[k] > pos) break;
                size_misses[k] = sat_bump(size_misses[k]);
            end
        end
        recency.push_front(addr);
        stamp_count = stamp_count + 1'b1;
    endfunction

    function automatic void queue_report(input logic typed, input logic [COUNT_W-1:0] misses);
        int k;
        int n;
        logic [COUNT_W:0] sum;
        t_miss_report r;
        n = levels_in_use();
        for (k = 0; k < n; k++) begin
            sum = size_misses[k] + cold_total;
            r.level = k[LEVEL_W-1:0];
            r.miss_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            if (typed) r.miss_count = misses;
            r.overflow = overflow_seen;
            r.last = (k + 1 == n);
            pending_counts.push_back(r);
        end
        for (k = 0; k < SIZE_REGS; k++) size_misses[k] = '0;
        cold_total = '0;
    endfunction

    function automatic void note_fault(input string msg);
        faults++;
        if (faults <= 10) $display("mismatch: %s", msg);
    endfunction

    always @(posedge i_clk) begin : count_check
        t_miss_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            counts_seen++;
            if (pending_counts.size() == 0) begin
                note_fault($sformatf("unexpected beat level %0d misses %0d", o_level,
                                     o_miss_count));
            end else begin
                want = pending_counts.pop_front();
                if (o_level !== want.level)
                    note_fault($sformatf("level exp %0d got %0d", want.level, o_level));
                if (o_miss_count !== want.miss_count)
                    note_fault($sformatf("level %0d miss_count exp %0d got %0d", want.level,
                                         want.miss_count, o_miss_count));
                if (o_overflow !== want.overflow)
                    note_fault($sformatf("level %0d overflow exp %0b got %0b", want.level,
                                         want.overflow, o_overflow));
                if (o_last !== want.last)
                    note_fault($sformatf("level %0d last exp %0b got %0b", want.level,
                                         want.last, o_last));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_mode == lsdmc_pkg::MODE_REPORT) queue_report(has_typed_count, typed_count);
            else apply_access(i_block_address);
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 32);
    end

    // hold the write enable high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            lsdmc_pkg::CFG_ACTIVE_LEVELS: cfg_levels = data[ACT_W-1:0];
            lsdmc_pkg::CFG_SIZE_ZERO:     cfg_size[0] = data[SIZE_W-1:0];
            lsdmc_pkg::CFG_SIZE_ONE:      cfg_size[1] = data[SIZE_W-1:0];
            lsdmc_pkg::CFG_SIZE_TWO:      cfg_size[2] = data[SIZE_W-1:0];
            lsdmc_pkg::CFG_SIZE_THREE:    cfg_size[3] = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input int p);
        write_reg(lsdmc_pkg::CFG_ACTIVE_LEVELS, setting_table[p][0]);
        write_reg(lsdmc_pkg::CFG_SIZE_ZERO, setting_table[p][1]);
        write_reg(lsdmc_pkg::CFG_SIZE_ONE, setting_table[p][2]);
        write_reg(lsdmc_pkg::CFG_SIZE_TWO, setting_table[p][3]);
        write_reg(lsdmc_pkg::CFG_SIZE_THREE, setting_table[p][4]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic hold_off(input int extra, input bit drain);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drain && pending_counts.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic mode, input logic [AW-1:0] addr, input logic typed,
                             input logic [COUNT_W-1:0] misses);
        if (!steady && $urandom_range(99) < 32) hold_off($urandom_range(23), 1'b0);
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_block_address <= addr;
        has_typed_count <= typed;
        typed_count <= misses;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (mode == lsdmc_pkg::MODE_REPORT) reports_sent++;
        else accesses_sent++;
    endtask

    initial begin : stimulus
        int k;
        int p;
        int n_items;
        int roll;
        int ws;
        logic [31:0] word;
        logic [AW-1:0] ws_base;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_mode <= MODE_ACCESS;
        i_block_address <= '0;
        has_typed_count <= 1'b0;
        typed_count <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= lsdmc_pkg::CFG_ACTIVE_LEVELS;
        i_cfg_data <= '0;

        recency.delete();
        stamp_count = '0;
        cold_total = '0;
        overflow_seen = 1'b0;
        cfg_levels = lsdmc_pkg::ACTIVE_RESET;
        for (k = 0; k < SIZE_REGS; k++) begin
            size_misses[k] = '0;
            cfg_size[k] = lsdmc_pkg::SIZE_RESET[k];
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_setting(0);
        for (k = 0; k < DIRECTED_ROWS; k++)
            send_beat(directed_rows[k].mode, directed_rows[k].addr, directed_rows[k].typed,
                      directed_rows[k].misses);

        for (p = 1; p < PHASES; p++) begin
            hold_off(SETTLE_CYCLES, 1'b1);
            steady <= (p == 2);
            load_setting(p);
            word = $urandom();
            ws_base = word[AW-1:0];
            ws = $urandom_range(20, 3);
            n_items = 0;
            while (n_items < RANDOM_PER_PHASE) begin
                roll = $urandom_range(99);
                word = $urandom();
                if (roll < 18) begin
                    send_beat(lsdmc_pkg::MODE_REPORT, word[AW-1:0], 1'b0, '0);
                    if (!steady && word[31:30] == 2'b00) hold_off(0, 1'b1);
                end else if (roll < 30) begin
                    send_beat(MODE_ACCESS, word[AW-1:0], 1'b0, '0);
                end else begin
                    send_beat(MODE_ACCESS, ws_base + AW'(word % ws), 1'b0, '0);
                end
                n_items++;
            end
        end

        steady <= 1'b0;
        hold_off(SETTLE_CYCLES, 1'b1);
        if (pending_counts.size() != 0)
            note_fault($sformatf("%0d count beats never arrived", pending_counts.size()));

        $display("covered %0d access and %0d report beats over %0d cache settings",
                 accesses_sent, reports_sent, PHASES);
        $display("checked %0d count beats, %0d mismatches", counts_seen, faults);
        if (faults == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lsdmc_pkg.sv
rtl/lsdmc_dpath.sv
rtl/lsdmc_ctrl.sv
rtl/lru_stack_distance_miss_counter.sv
tb/lru_stack_distance_miss_counter_test.sv
